/* rtl/core/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the playback position sequencer: word
// layouts of the request and response channels, command and play kind codes,
// and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

   // field widths
   localparam int TIME_BITS = 24;
   localparam int STEP_BITS = 16;
   localparam int KIND_BITS = 4;
   localparam int PROG_BITS = 17;
   localparam int CSR_INDEX_BITS = 1;

   // signed working width of the position arithmetic, two spare bits
   localparam int CALC_BITS = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 2;

   // unsigned Q1.16 one and half
   localparam logic [PROG_BITS-1:0] ONE_Q16  = PROG_BITS'(65536);
   localparam logic [PROG_BITS-1:0] HALF_Q16 = PROG_BITS'(32768);

   // command codes
   typedef enum logic [1:0] {
      MODE_TICK         = 2'd0,
      MODE_PLAY         = 2'd1,
      MODE_STOP         = 2'd2,
      MODE_SET_PROGRESS = 2'd3
   } mode_type;

   // play kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ONCE              = 4'd0,
      KIND_LOOP              = 4'd1,
      KIND_PINGPONG          = 4'd2,
      KIND_PINGPONG_LOOP     = 4'd3,
      KIND_ONCE_REV          = 4'd4,
      KIND_LOOP_REV          = 4'd5,
      KIND_PINGPONG_REV      = 4'd6,
      KIND_PINGPONG_LOOP_REV = 4'd7,
      KIND_STOP_HALF         = 4'd8
   } play_kind_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DURATION    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DELAY = 1'b1;

   // request word
   typedef struct packed {
      mode_type                 mode;
      logic [STEP_BITS-1:0]     time_step;
      logic [KIND_BITS-1:0]     play_kind;
      logic [PROG_BITS-1:0]     progress;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [TIME_BITS-1:0]     position;
      logic                     playing;
      logic                     forward;
      logic                     finished;
      logic                     looped;
      logic                     start_event;
      logic                     complete_event;
   } rsp_word_type;

endpackage

`default_nettype wire

/* rtl/core/playback_position_sequencer.sv */
// ----------------------------------------------------------------------------
// playback_position_sequencer
// Tracks a playback position between zero and the configured duration under
// nine play kinds, applying ticks, play, stop and set-progress commands.
// ----------------------------------------------------------------------------
//
//  channel  ports                          direction  moves
//  req      req_valid req_ready req_word   in         one command word
//  rsp      rsp_valid rsp_ready rsp_word   out        one result word
//  csr      csr_valid csr_ready csr_index  in         one register write
//           csr_data
//
//  one word per cycle sustained while rsp_ready holds; a taken word goes to
//  the input register, then to the result register once it is free: update
//  logic on the input register loads the result and playback state together
//  synchronous reset clears the playback state and both register stages
//  a stalled rsp holds its word; req stays open until the input register
//  also holds a word that cannot move on
//  csr writes are always taken
//
`default_nettype none

module playback_position_sequencer (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  pps_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output pps_pkg::rsp_word_type                  rsp_word,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [pps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  [pps_pkg::TIME_BITS-1:0]          csr_data
);

   localparam int TB = pps_pkg::TIME_BITS;
   localparam int CB = pps_pkg::CALC_BITS;
   localparam int PB = TB + pps_pkg::PROG_BITS + 1;

   // signed zero for the position compares
   localparam logic signed [CB-1:0] CALC_ZERO = '0;

   // configuration registers
   logic [TB-1:0] duration_ff;
   logic [TB-1:0] start_delay_ff;

   // playback state
   logic [TB-1:0]                position_ff, position_in;
   logic [TB-1:0]                delay_left_ff, delay_left_in;
   pps_pkg::play_kind_type       kind_ff, kind_in;
   logic                         moving_up_ff, moving_up_in;
   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic                         wrapped_ff, wrapped_in;
   logic                         started_ff, started_in;

   // pipeline
   logic                         s1_valid_ff;
   pps_pkg::req_word_type        s1_word_ff;
   logic                         rsp_valid_ff;
   pps_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;
   logic                         advance;

   // update datapath
   logic signed [CB-1:0]         pos_calc;
   logic signed [CB-1:0]         dur_calc;
   logic signed [CB-1:0]         dt_calc;
   logic signed [CB-1:0]         step_calc;
   logic signed [CB-1:0]         delay_calc;
   logic signed [CB-1:0]         p_calc;
   logic                         moving;
   logic                         zero_dur;
   logic                         at_end;
   logic                         at_start;
   logic                         is_ping;
   logic                         is_ping_rev;
   logic                         is_rev_kind;
   logic                         ev_start;
   logic                         ev_complete;
   logic [pps_pkg::PROG_BITS-1:0] frac;
   logic [PB-1:0]                prog_prod;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff    <= '0;
         start_delay_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pps_pkg::CSR_DURATION:    duration_ff    <= csr_data;
            pps_pkg::CSR_START_DELAY: start_delay_ff <= csr_data;
            default:                  duration_ff    <= duration_ff;
         endcase
      end
   end

   // handshake: input register moves on when the result register is free
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // playback state register
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         delay_left_ff <= '0;
         kind_ff       <= pps_pkg::KIND_ONCE;
         moving_up_ff  <= 1'b1;
         active_ff     <= 1'b0;
         done_ff       <= 1'b0;
         wrapped_ff    <= 1'b0;
         started_ff    <= 1'b0;
      end else if (advance) begin
         position_ff   <= position_in;
         delay_left_ff <= delay_left_in;
         kind_ff       <= kind_in;
         moving_up_ff  <= moving_up_in;
         active_ff     <= active_in;
         done_ff       <= done_in;
         wrapped_ff    <= wrapped_in;
         started_ff    <= started_in;
      end
   end

   // set progress: duration times fraction (one minus fraction when moving down), rounded half up
   always_comb begin
      frac = (s1_word_ff.progress > pps_pkg::ONE_Q16) ? pps_pkg::ONE_Q16
                                                      : s1_word_ff.progress;
      if (!moving_up_ff) begin
         frac = pps_pkg::ONE_Q16 - frac;
      end
      prog_prod = PB'(duration_ff) * PB'(frac) + PB'(pps_pkg::HALF_Q16);
   end

   // kind classes and tick operands
   assign is_ping     = (kind_ff == pps_pkg::KIND_PINGPONG) ||
                        (kind_ff == pps_pkg::KIND_PINGPONG_LOOP);
   assign is_ping_rev = (kind_ff == pps_pkg::KIND_PINGPONG_REV) ||
                        (kind_ff == pps_pkg::KIND_PINGPONG_LOOP_REV);
   assign is_rev_kind = (s1_word_ff.play_kind >= pps_pkg::KIND_ONCE_REV) &&
                        (s1_word_ff.play_kind <= pps_pkg::KIND_PINGPONG_LOOP_REV);
   assign pos_calc    = CB'(position_ff);
   assign dur_calc    = CB'(duration_ff);
   assign step_calc   = CB'(s1_word_ff.time_step);
   assign delay_calc  = CB'(delay_left_ff);
   assign zero_dur    = (duration_ff == '0);

   // next state and result
   always_comb begin
      position_in   = position_ff;
      delay_left_in = delay_left_ff;
      kind_in       = kind_ff;
      moving_up_in  = moving_up_ff;
      active_in     = active_ff;
      done_in       = done_ff;
      wrapped_in    = wrapped_ff;
      started_in    = started_ff;
      ev_start      = 1'b0;
      ev_complete   = 1'b0;
      moving        = 1'b0;
      dt_calc       = step_calc;
      p_calc        = pos_calc;
      at_end        = 1'b0;
      at_start      = 1'b0;

      unique case (s1_word_ff.mode)
         pps_pkg::MODE_TICK: begin
            // spend the start delay first
            if (active_ff) begin
               moving = 1'b1;
               if (delay_left_ff != '0) begin
                  if (step_calc < delay_calc) begin
                     delay_left_in = delay_left_ff - TB'(s1_word_ff.time_step);
                     moving        = 1'b0;
                  end else begin
                     dt_calc       = step_calc - delay_calc;
                     delay_left_in = '0;
                  end
               end
            end
            if (moving) begin
               if (!started_ff) begin
                  started_in = 1'b1;
                  ev_start   = 1'b1;
               end
               p_calc     = moving_up_ff ? (pos_calc + dt_calc) : (pos_calc - dt_calc);
               wrapped_in = 1'b0;
               at_end     = zero_dur || (p_calc >= dur_calc);
               at_start   = !zero_dur && (p_calc <= CALC_ZERO);

               // wrap, bounce and finish rules
               if (kind_ff == pps_pkg::KIND_ONCE && at_end) begin
                  active_in   = 1'b0;
                  done_in     = 1'b1;
                  ev_complete = 1'b1;
               end else if (kind_ff == pps_pkg::KIND_LOOP && at_end) begin
                  p_calc     = '0;
                  wrapped_in = 1'b1;
               end else if (is_ping && at_end && moving_up_ff) begin
                  moving_up_in = 1'b0;
                  p_calc       = dur_calc;
               end else if (is_ping && at_start && !moving_up_ff) begin
                  moving_up_in = 1'b1;
                  p_calc       = '0;
                  if (kind_ff == pps_pkg::KIND_PINGPONG) begin
                     active_in   = 1'b0;
                     done_in     = 1'b1;
                     ev_complete = 1'b1;
                  end else begin
                     wrapped_in = 1'b1;
                  end
               end else if (kind_ff == pps_pkg::KIND_ONCE_REV && at_start) begin
                  active_in   = 1'b0;
                  done_in     = 1'b1;
                  ev_complete = 1'b1;
               end else if (kind_ff == pps_pkg::KIND_LOOP_REV && at_start) begin
                  p_calc     = dur_calc;
                  wrapped_in = 1'b1;
               end else if (is_ping_rev && at_start && !moving_up_ff) begin
                  moving_up_in = 1'b1;
                  p_calc       = '0;
               end else if (is_ping_rev && at_end && moving_up_ff) begin
                  moving_up_in = 1'b0;
                  p_calc       = dur_calc;
                  if (kind_ff == pps_pkg::KIND_PINGPONG_REV) begin
                     active_in   = 1'b0;
                     done_in     = 1'b1;
                     ev_complete = 1'b1;
                  end
               end else if (kind_ff == pps_pkg::KIND_STOP_HALF &&
                            (zero_dur || p_calc > (dur_calc >>> 1))) begin
                  p_calc = dur_calc >>> 1;
               end

               // clamp to 0..duration
               if (p_calc < CALC_ZERO) begin
                  p_calc = '0;
               end else if (p_calc > dur_calc) begin
                  p_calc = dur_calc;
               end
               position_in = p_calc[TB-1:0];
            end
         end
         pps_pkg::MODE_PLAY: begin
            // unknown kinds are ignored
            if (s1_word_ff.play_kind <= pps_pkg::KIND_STOP_HALF) begin
               position_in   = is_rev_kind ? duration_ff : '0;
               moving_up_in  = !is_rev_kind;
               delay_left_in = start_delay_ff;
               active_in     = 1'b1;
               kind_in       = pps_pkg::play_kind_type'(s1_word_ff.play_kind);
               done_in       = 1'b0;
            end
         end
         pps_pkg::MODE_STOP: begin
            active_in = 1'b0;
         end
         pps_pkg::MODE_SET_PROGRESS: begin
            position_in = prog_prod[TB+15:16];
         end
         default: begin
            active_in = active_ff;
         end
      endcase

      rsp_word_in.position       = position_in;
      rsp_word_in.playing        = active_in;
      rsp_word_in.forward        = moving_up_in;
      rsp_word_in.finished       = done_in;
      rsp_word_in.looped         = wrapped_in;
      rsp_word_in.start_event    = ev_start;
      rsp_word_in.complete_event = ev_complete;
   end

`ifndef SYNTH
   // a completion always leaves the block stopped and finished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.complete_event |->
         rsp_word_ff.finished && !rsp_word_ff.playing)
      else $error("complete word without finished state");

   // the start pulse fires once per reset
   assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("start marker cleared outside reset");

   // a start pulse comes with a running or just finished playback
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.start_event |->
         rsp_word_ff.playing || rsp_word_ff.finished)
      else $error("start word while idle");

   // playing and finished exclude each other
   assert property (@(posedge clock) disable iff (reset)
      !(active_ff && done_ff))
      else $error("active and done both set");
`endif

endmodule

`default_nettype wire
